@@ hw/rtl/smth_pkg.sv @@
// shared constants, types and phase codes of the splitmix tile hasher
package smth_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 21;
    localparam int BYTES   = WORD_W / 8;

    localparam logic [WORD_W-1:0] GOLDEN_ADD = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified word handed from the front to the back
    typedef struct packed {
        logic              empty_tile;
        logic              first;
        logic              last;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  length;
    } t_op;

    // steps of one mixing round in the back
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL_A,
        PH_XOR_B,
        PH_MUL_B,
        PH_FINAL
    } t_phase;

endpackage

@@ hw/rtl/smth_front.sv @@
// front: accepts words, tracks open tiles, masks the last word, builds ops
module smth_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [smth_pkg::WORD_W-1:0]  i_data_word,
    input  logic [smth_pkg::COUNT_W-1:0] i_valid_bytes,
    input  logic                         i_last_word,
    input  logic [smth_pkg::LEN_W-1:0]   i_tile_length,
    input  logic                         i_q_full,
    output logic                         o_full,
    output logic                         o_q_push,
    output smth_pkg::t_op                o_q_op
);

    logic r_open;
    logic n_open;
    logic accept;
    logic is_empty_tile;
    logic full_word;
    logic [smth_pkg::WORD_W-1:0] masked_word;

    assign o_full = i_q_full;
    assign accept = i_push & ~i_q_full;

    // empty tile only when no tile is open
    assign is_empty_tile = ~r_open && (i_tile_length == '0);

    // byte masking of a partial last word
    assign full_word = ~i_last_word || (i_valid_bytes == '0)
                       || (i_valid_bytes >= smth_pkg::COUNT_W'(smth_pkg::BYTES));

    always_comb begin
        for (int b = 0; b < smth_pkg::BYTES; b++) begin
            if (full_word || (smth_pkg::COUNT_W'(b) < i_valid_bytes)) begin
                masked_word[b*8 +: 8] = i_data_word[b*8 +: 8];
            end else begin
                masked_word[b*8 +: 8] = 8'h00;
            end
        end
    end

    // op sent to the queue
    always_comb begin
        o_q_push          = accept;
        o_q_op.empty_tile = is_empty_tile;
        o_q_op.first      = ~r_open;
        o_q_op.last       = i_last_word;
        o_q_op.word       = masked_word;
        o_q_op.length     = i_tile_length;
    end

    // tile open tracking
    always_comb begin
        n_open = r_open;
        if (accept && !is_empty_tile) begin
            n_open = ~i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

endmodule

@@ hw/rtl/smth_queue.sv @@
// short first-in first-out queue of ops between front and back
module smth_queue #(
    parameter int DEPTH = smth_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smth_pkg::t_op i_data,
    output logic          o_full,
    input  logic          i_pop,
    output smth_pkg::t_op o_data,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    smth_pkg::t_op r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/smth_back.sv @@
// back: runs the mixing round over several steps and holds the result word
module smth_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smth_pkg::t_op               i_q_op,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [smth_pkg::WORD_W-1:0] o_tile_hash
);

    localparam int W = smth_pkg::WORD_W;
    localparam int H = W / 2;

    smth_pkg::t_phase r_phase, n_phase;
    logic [W-1:0] r_hash, n_hash;
    logic [W-1:0] r_x, n_x;
    logic [W-1:0] r_p0, n_p0;
    logic [H-1:0] r_p1, n_p1;
    logic [H-1:0] r_p2, n_p2;
    logic         r_last, n_last;
    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_out_hash, n_out_hash;

    logic         slot_free;
    logic [W-1:0] mul_k;
    logic [W-1:0] prod_lo, prod_hl, prod_lh;
    logic [W-1:0] mul_sum;
    logic [W-1:0] seed_acc;
    logic [W-1:0] pre_z;

    assign o_empty     = ~r_out_valid;
    assign o_tile_hash = r_out_hash;
    assign slot_free   = ~r_out_valid | i_pop;

    // partial products lo*lo, hi*lo and lo*hi of the 32-bit halves of r_x and a constant
    assign mul_k   = (r_phase == smth_pkg::PH_MUL_B) ? smth_pkg::MIX_MUL_B
                                                      : smth_pkg::MIX_MUL_A;
    assign prod_lo = W'(r_x[H-1:0]) * W'(mul_k[H-1:0]);
    assign prod_hl = W'(r_x[W-1:H]) * W'(mul_k[H-1:0]);
    assign prod_lh = W'(r_x[H-1:0]) * W'(mul_k[W-1:H]);

    // reassembly of the low word of the product
    assign mul_sum = r_p0 + {r_p1 + r_p2, {H{1'b0}}};

    // first step of the round on the popped op
    assign seed_acc = i_q_op.first
                      ? (smth_pkg::GOLDEN_ADD ^ {{(W - smth_pkg::LEN_W){1'b0}}, i_q_op.length})
                      : r_hash;
    assign pre_z    = (seed_acc ^ i_q_op.word) + smth_pkg::GOLDEN_ADD;

    // sequencer and datapath next values
    always_comb begin
        n_phase     = r_phase;
        n_hash      = r_hash;
        n_x         = r_x;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_last      = r_last;
        n_out_hash  = r_out_hash;
        n_out_valid = r_out_valid & ~i_pop;
        o_q_pop     = 1'b0;
        unique case (r_phase)
            smth_pkg::PH_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_op.empty_tile) begin
                        if (slot_free) begin
                            o_q_pop     = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_hash  = '0;
                        end
                    end else if (!i_q_op.last || slot_free) begin
                        o_q_pop = 1'b1;
                        n_x     = pre_z ^ (pre_z >> smth_pkg::SHIFT_A);
                        n_last  = i_q_op.last;
                        n_phase = smth_pkg::PH_MUL_A;
                    end
                end
            end
            smth_pkg::PH_MUL_A: begin
                n_p0    = prod_lo;
                n_p1    = prod_hl[H-1:0];
                n_p2    = prod_lh[H-1:0];
                n_phase = smth_pkg::PH_XOR_B;
            end
            smth_pkg::PH_XOR_B: begin
                n_x     = mul_sum ^ (mul_sum >> smth_pkg::SHIFT_B);
                n_phase = smth_pkg::PH_MUL_B;
            end
            smth_pkg::PH_MUL_B: begin
                n_p0    = prod_lo;
                n_p1    = prod_hl[H-1:0];
                n_p2    = prod_lh[H-1:0];
                n_phase = smth_pkg::PH_FINAL;
            end
            smth_pkg::PH_FINAL: begin
                n_hash  = mul_sum ^ (mul_sum >> smth_pkg::SHIFT_C);
                n_phase = smth_pkg::PH_IDLE;
                if (r_last) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = mul_sum ^ (mul_sum >> smth_pkg::SHIFT_C);
                end
            end
            default: begin
                n_phase = smth_pkg::PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= smth_pkg::PH_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_p0       <= n_p0;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_last     <= n_last;
        r_out_hash <= n_out_hash;
    end

    // a waiting result word is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_hash)))
        else $error("result word overwritten while waiting");

    // the slot is free whenever a tile finishes
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == smth_pkg::PH_FINAL && r_last) |-> slot_free)
        else $error("tile finished with result slot occupied");

    // ops are taken only between rounds
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_phase == smth_pkg::PH_IDLE && !i_q_empty))
        else $error("queue popped during a round");

    // a round always runs through all its steps
    a_round_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == smth_pkg::PH_MUL_A) |=> (r_phase == smth_pkg::PH_XOR_B) ##1
        (r_phase == smth_pkg::PH_MUL_B) ##1 (r_phase == smth_pkg::PH_FINAL))
        else $error("mixing round out of sequence");

endmodule

@@ hw/rtl/splitmix_tile_hash_top.sv @@
// top level of the splitmix tile hasher: front, op queue and mixing back
//
// Input channel: a word is taken at a rising edge with i_push high and
// o_full low. The first word of a tile carries i_tile_length; i_last_word
// ends the tile, and i_valid_bytes masks the upper bytes of that last word.
// A tile length of zero with no tile open gives a hash of zero without a mixing round.
// Result channel: while o_empty is low, o_tile_hash holds the oldest hash;
// it is taken at a rising edge with i_pop high.
// Rounds: the back takes no new op from the queue until the mixing round of
// the current word has run through all its steps. The round's two 64-bit
// multiplies each run as 32-bit partial products over two steps chained on
// the running hash. The queue of QUEUE_DEPTH words lets the front keep
// accepting words while a round is in progress.
// Reset: synchronous, clears the running hash, the open-tile flag, the queue
// and the result slot. When the receiver stalls, the result slot holds, the
// back stops before any op that produces a hash, and o_full rises once the
// queue fills.
module splitmix_tile_hash_top #(
    parameter int QUEUE_DEPTH = smth_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [smth_pkg::WORD_W-1:0]  i_data_word,
    input  logic [smth_pkg::COUNT_W-1:0] i_valid_bytes,
    input  logic                         i_last_word,
    input  logic [smth_pkg::LEN_W-1:0]   i_tile_length,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [smth_pkg::WORD_W-1:0]  o_tile_hash
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    smth_pkg::t_op q_in_op;
    smth_pkg::t_op q_out_op;

    // word intake and classification
    smth_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .i_tile_length (i_tile_length),
        .i_q_full      (q_full),
        .o_full        (o_full),
        .o_q_push      (q_push),
        .o_q_op        (q_in_op)
    );

    // op queue
    smth_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_op),
        .o_empty (q_empty)
    );

    // mixing rounds and result slot
    smth_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_op      (q_out_op),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_tile_hash (o_tile_hash)
    );

endmodule
